// ===== hw/rtl/c16df_pkg.sv =====
// shared types, constants and the crc step function of the crc16 frame deframer
`timescale 1ns / 1ps
`default_nettype none

package c16df_pkg;

  // width of the max payload register and the payload position counter
  localparam int unsigned LEN_BITS = 12;

  // frame layout
  localparam logic [3:0] HEADER_LAST = 4'd11;

  // crc-16/modbus
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // largest value of a 12-bit result field
  localparam logic [LEN_BITS-1:0] FIELD_MAX = '1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC,
    PH_DISCARD
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_CRC_ERR  = 3'd2,
    KIND_LEN_ERR  = 3'd3,
    KIND_TRUNC    = 3'd4
  } kind_e;

  // one result transaction
  typedef struct packed {
    kind_e               kind;
    logic [7:0]          payload_byte;
    logic [LEN_BITS-1:0] byte_index;
    logic [31:0]         cmd;
    logic [31:0]         para;
    logic [LEN_BITS-1:0] payload_len;
  } result_t;

  // one byte of reflected crc, unrolled over eight bit steps
  function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/c16df_in_reg.sv =====
// input register stage of the crc16 frame deframer
`timescale 1ns / 1ps
`default_nettype none

module c16df_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       chunk_end_i,
  input  wire logic       advance_i,
  output logic            s1_valid_o,
  output logic [7:0]      s1_data_o,
  output logic            s1_end_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       end_q;
  logic       accept;

  // slot is free when empty or when its transaction moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      end_q  <= chunk_end_i;
    end
  end

  assign s1_valid_o = valid_q;
  assign s1_data_o  = data_q;
  assign s1_end_o   = end_q;

endmodule

`default_nettype wire

// ===== hw/rtl/c16df_core.sv =====
// frame parser state, crc update and result formation of the crc16 frame deframer
`timescale 1ns / 1ps
`default_nettype none

module c16df_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           item_valid_i,
  input  wire logic [7:0]                     data_i,
  input  wire logic                           chunk_end_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [c16df_pkg::LEN_BITS-1:0] cfg_wdata_i,
  output logic                                res_valid_o,
  output c16df_pkg::result_t                  res_o
);

  c16df_pkg::phase_e                phase_q, phase_d;
  logic [c16df_pkg::LEN_BITS-1:0]   pos_q, pos_d;
  logic [15:0]                      crc_q, crc_d;
  logic [31:0]                      cmd_q, cmd_d;
  logic [31:0]                      para_q, para_d;
  logic [31:0]                      len_q, len_d;
  logic [c16df_pkg::LEN_BITS-1:0]   max_q;

  logic                             in_header;
  logic                             hdr_first;
  logic [3:0]                       hdr_pos;
  logic                             hdr_done;
  logic [15:0]                      crc_new;
  logic [31:0]                      cmd_hdr, para_hdr, len_hdr;
  logic [31:0]                      cmd_cur, para_cur, len_cur;
  logic [c16df_pkg::LEN_BITS-1:0]   len_sat;
  logic                             len_over;
  logic                             len_zero;
  logic [c16df_pkg::LEN_BITS-1:0]   pos_inc;
  logic                             payload_done;

  // header bookkeeping; position zero opens a new frame
  assign in_header = (phase_q == c16df_pkg::PH_HEADER);
  assign hdr_first = (pos_q == '0) || (pos_q > c16df_pkg::LEN_BITS'(c16df_pkg::HEADER_LAST));
  assign hdr_pos   = hdr_first ? 4'd0 : pos_q[3:0];
  assign hdr_done  = (hdr_pos == c16df_pkg::HEADER_LAST);

  // crc over every frame byte
  assign crc_new = c16df_pkg::crc_byte((in_header && hdr_first) ? c16df_pkg::CRC_INIT : crc_q,
                                       data_i);

  // little-endian word assembly
  always_comb begin
    cmd_hdr  = hdr_first ? 32'd0 : cmd_q;
    para_hdr = hdr_first ? 32'd0 : para_q;
    len_hdr  = hdr_first ? 32'd0 : len_q;
    if (hdr_pos < 4'd4) begin
      cmd_hdr[{hdr_pos[1:0], 3'b000} +: 8] = data_i;
    end else if (hdr_pos < 4'd8) begin
      para_hdr[{hdr_pos[1:0], 3'b000} +: 8] = data_i;
    end else begin
      len_hdr[{hdr_pos[1:0], 3'b000} +: 8] = data_i;
    end
  end

  // words seen by a frame end report
  assign cmd_cur  = in_header ? cmd_hdr  : cmd_q;
  assign para_cur = in_header ? para_hdr : para_q;
  assign len_cur  = in_header ? len_hdr  : len_q;
  assign len_sat  = (len_cur[31:c16df_pkg::LEN_BITS] != '0) ? c16df_pkg::FIELD_MAX
                                                            : len_cur[c16df_pkg::LEN_BITS-1:0];

  // length checks and payload counting
  assign len_over     = (len_hdr > {{(32 - c16df_pkg::LEN_BITS){1'b0}}, max_q});
  assign len_zero     = (len_hdr == 32'd0);
  assign pos_inc      = pos_q + c16df_pkg::LEN_BITS'(1);
  assign payload_done = ({{(32 - c16df_pkg::LEN_BITS){1'b0}}, pos_inc} >= len_q);

  // next state
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    cmd_d   = cmd_q;
    para_d  = para_q;
    len_d   = len_q;
    if (item_valid_i) begin
      case (phase_q)
        c16df_pkg::PH_HEADER: begin
          crc_d  = crc_new;
          cmd_d  = cmd_hdr;
          para_d = para_hdr;
          len_d  = len_hdr;
          if (hdr_done) begin
            pos_d = '0;
            if (len_over) begin
              phase_d = chunk_end_i ? c16df_pkg::PH_HEADER : c16df_pkg::PH_DISCARD;
            end else if (chunk_end_i) begin
              phase_d = c16df_pkg::PH_HEADER;
            end else begin
              phase_d = len_zero ? c16df_pkg::PH_CRC : c16df_pkg::PH_PAYLOAD;
            end
          end else if (chunk_end_i) begin
            pos_d = '0;
          end else begin
            pos_d = c16df_pkg::LEN_BITS'(hdr_pos) + c16df_pkg::LEN_BITS'(1);
          end
        end
        c16df_pkg::PH_PAYLOAD: begin
          crc_d = crc_new;
          if (chunk_end_i) begin
            phase_d = c16df_pkg::PH_HEADER;
            pos_d   = '0;
          end else if (payload_done) begin
            phase_d = c16df_pkg::PH_CRC;
            pos_d   = '0;
          end else begin
            pos_d = pos_inc;
          end
        end
        c16df_pkg::PH_CRC: begin
          crc_d = crc_new;
          if (pos_q != '0) begin
            pos_d = '0;
            if (crc_new == 16'd0 || chunk_end_i) begin
              phase_d = c16df_pkg::PH_HEADER;
            end else begin
              phase_d = c16df_pkg::PH_DISCARD;
            end
          end else if (chunk_end_i) begin
            phase_d = c16df_pkg::PH_HEADER;
            pos_d   = '0;
          end else begin
            pos_d = pos_inc;
          end
        end
        c16df_pkg::PH_DISCARD: begin
          if (chunk_end_i) begin
            phase_d = c16df_pkg::PH_HEADER;
            pos_d   = '0;
          end
        end
        default: begin
          phase_d = c16df_pkg::PH_HEADER;
          pos_d   = '0;
        end
      endcase
    end
  end

  // result formation
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.kind         = c16df_pkg::KIND_PAYLOAD;
    res_o.payload_byte = 8'd0;
    res_o.byte_index   = '0;
    res_o.cmd          = cmd_cur;
    res_o.para         = para_cur;
    res_o.payload_len  = len_sat;
    if (item_valid_i) begin
      case (phase_q)
        c16df_pkg::PH_HEADER: begin
          if (hdr_done && len_over) begin
            res_valid_o = 1'b1;
            res_o.kind  = c16df_pkg::KIND_LEN_ERR;
          end else if (chunk_end_i) begin
            res_valid_o = 1'b1;
            res_o.kind  = c16df_pkg::KIND_TRUNC;
          end
        end
        c16df_pkg::PH_PAYLOAD: begin
          res_valid_o = 1'b1;
          if (chunk_end_i) begin
            res_o.kind = c16df_pkg::KIND_TRUNC;
          end else begin
            res_o.kind         = c16df_pkg::KIND_PAYLOAD;
            res_o.payload_byte = data_i;
            res_o.byte_index   = pos_q;
            res_o.cmd          = 32'd0;
            res_o.para         = 32'd0;
            res_o.payload_len  = '0;
          end
        end
        c16df_pkg::PH_CRC: begin
          if (pos_q != '0) begin
            res_valid_o = 1'b1;
            res_o.kind  = (crc_new == 16'd0) ? c16df_pkg::KIND_GOOD : c16df_pkg::KIND_CRC_ERR;
          end else if (chunk_end_i) begin
            res_valid_o = 1'b1;
            res_o.kind  = c16df_pkg::KIND_TRUNC;
          end
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= c16df_pkg::PH_HEADER;
      pos_q   <= '0;
      crc_q   <= c16df_pkg::CRC_INIT;
      cmd_q   <= 32'd0;
      para_q  <= 32'd0;
      len_q   <= 32'd0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      cmd_q   <= cmd_d;
      para_q  <= para_d;
      len_q   <= len_d;
    end
  end

  // max payload configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= c16df_pkg::LEN_BITS'(1026);
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/c16df_out_reg.sv =====
// result register stage of the crc16 frame deframer
`timescale 1ns / 1ps
`default_nettype none

module c16df_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s1_valid_i,
  output logic                    advance_o,
  input  wire logic               res_valid_i,
  input  wire c16df_pkg::result_t res_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output c16df_pkg::result_t      res_o
);

  logic               valid_q, valid_d;
  c16df_pkg::result_t res_q;

  // a staged transaction moves on when the result slot is free or draining
  assign advance_o = s1_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (advance_o) begin
      valid_d = res_valid_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload capture
  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/crc16_frame_deframer_top.sv =====
// Streaming deframer for length-prefixed frames checked by crc-16/modbus.
// Path: a byte accepted into the input register is parsed into the result register once
// the result slot is free or draining, and its result, if any, is then offered on out_valid_o.
// Throughput: one byte per cycle; a result waiting on out_ready holds the input stage.
// Reset: asynchronous, active low; parser returns to frame start, crc to 0xFFFF,
// max payload to 1026, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        chunk_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic [11:0]      byte_index_o,
  output logic [31:0]      cmd_o,
  output logic [31:0]      para_o,
  output logic [11:0]      payload_len_o,
  input  wire logic        cfg_we_i,
  input  wire logic [11:0] cfg_wdata_i
);

  logic               advance;
  logic               s1_valid;
  logic [7:0]         s1_data;
  logic               s1_end;
  logic               res_valid;
  c16df_pkg::result_t res;
  c16df_pkg::result_t out_res;

  // input stage
  c16df_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .chunk_end_i (chunk_end_i),
    .advance_i   (advance),
    .s1_valid_o  (s1_valid),
    .s1_data_o   (s1_data),
    .s1_end_o    (s1_end)
  );

  // parser and crc
  c16df_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (advance),
    .data_i       (s1_data),
    .chunk_end_i  (s1_end),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result stage
  c16df_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .advance_o   (advance),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  // result fields to ports
  assign kind_o         = out_res.kind;
  assign payload_byte_o = out_res.payload_byte;
  assign byte_index_o   = out_res.byte_index;
  assign cmd_o          = out_res.cmd;
  assign para_o         = out_res.para;
  assign payload_len_o  = out_res.payload_len;

endmodule

`default_nettype wire

// ===== sim/tb_crc16_frame_deframer_top.sv =====
// testbench for the crc16 frame deframer: directed and random byte streams vs a predictor
`timescale 1ns / 1ps

module tb_crc16_frame_deframer_top;

  localparam int unsigned HDR_BYTES = 12;
  localparam time RUN_LIMIT = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        chunk_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [11:0] byte_index_o;
  logic [31:0] cmd_o;
  logic [31:0] para_o;
  logic [11:0] payload_len_o;
  logic        cfg_we_i;
  logic [11:0] cfg_wdata_i;

  // deframer state as seen by the predictor
  c16df_pkg::phase_e              rx_phase    = c16df_pkg::PH_HEADER;
  logic [12:0]                    rx_pos      = '0;
  logic [15:0]                    rx_crc      = c16df_pkg::CRC_INIT;
  logic [31:0]                    rx_cmd      = '0;
  logic [31:0]                    rx_para     = '0;
  logic [31:0]                    rx_len      = '0;
  logic [c16df_pkg::LEN_BITS-1:0] max_len_cfg = 12'd1026;

  c16df_pkg::result_t pending_results[$];
  logic [7:0]         frame_buf[$];
  int                 bytes_sent    = 0;
  int                 error_count   = 0;
  int                 hold_request  = 0;
  bit                 idle_on       = 1'b1;

  crc16_frame_deframer_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .chunk_end_i    (chunk_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .cmd_o          (cmd_o),
    .para_o         (para_o),
    .payload_len_o  (payload_len_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("tb_crc16_frame_deframer_top: done, errors");
    $finish;
  end

  // crc-16/modbus, one bit at a time, lsb first
  function automatic logic [15:0] crc_next(logic [15:0] acc, logic [7:0] din);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ din[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ c16df_pkg::CRC_POLY;
    end
    return acc;
  endfunction

  // frame end report from the current header words
  function automatic c16df_pkg::result_t frame_end(c16df_pkg::kind_e k);
    c16df_pkg::result_t r;
    r             = '0;
    r.kind        = k;
    r.cmd         = rx_cmd;
    r.para        = rx_para;
    r.payload_len = (rx_len > 32'(c16df_pkg::FIELD_MAX)) ? c16df_pkg::FIELD_MAX
                                                         : rx_len[c16df_pkg::LEN_BITS-1:0];
    return r;
  endfunction

  // predictor: advance the deframer by one byte, queue the result it causes
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    logic [4:0]                     sh;
    logic [c16df_pkg::LEN_BITS-1:0] idx;
    c16df_pkg::result_t             r;
    case (rx_phase)
      c16df_pkg::PH_HEADER: begin
        if (rx_pos >= HDR_BYTES) rx_pos = '0;
        if (rx_pos == 0) begin
          rx_crc  = c16df_pkg::CRC_INIT;
          rx_cmd  = '0;
          rx_para = '0;
          rx_len  = '0;
        end
        rx_crc = crc_next(rx_crc, b);
        sh     = {rx_pos[1:0], 3'b000};
        if (rx_pos < 4) rx_cmd |= 32'(b) << sh;
        else if (rx_pos < 8) rx_para |= 32'(b) << sh;
        else rx_len |= 32'(b) << sh;
        rx_pos++;
        if (rx_pos == HDR_BYTES) begin
          rx_pos = '0;
          if (rx_len > 32'(max_len_cfg)) begin
            pending_results.push_back(frame_end(c16df_pkg::KIND_LEN_ERR));
            if (!last) rx_phase = c16df_pkg::PH_DISCARD;
          end else if (last) begin
            pending_results.push_back(frame_end(c16df_pkg::KIND_TRUNC));
          end else if (rx_len == 0) begin
            rx_phase = c16df_pkg::PH_CRC;
          end else begin
            rx_phase = c16df_pkg::PH_PAYLOAD;
          end
        end else if (last) begin
          pending_results.push_back(frame_end(c16df_pkg::KIND_TRUNC));
          rx_pos = '0;
        end
      end
      c16df_pkg::PH_PAYLOAD: begin
        rx_crc = crc_next(rx_crc, b);
        idx    = rx_pos[c16df_pkg::LEN_BITS-1:0];
        rx_pos++;
        if (last) begin
          pending_results.push_back(frame_end(c16df_pkg::KIND_TRUNC));
          rx_phase = c16df_pkg::PH_HEADER;
          rx_pos   = '0;
        end else begin
          r              = '0;
          r.kind         = c16df_pkg::KIND_PAYLOAD;
          r.payload_byte = b;
          r.byte_index   = idx;
          pending_results.push_back(r);
          if (32'(rx_pos) >= rx_len) begin
            rx_phase = c16df_pkg::PH_CRC;
            rx_pos   = '0;
          end
        end
      end
      c16df_pkg::PH_CRC: begin
        rx_crc = crc_next(rx_crc, b);
        rx_pos++;
        if (rx_pos >= 2) begin
          rx_pos = '0;
          if (rx_crc == 16'h0000) begin
            pending_results.push_back(frame_end(c16df_pkg::KIND_GOOD));
            rx_phase = c16df_pkg::PH_HEADER;
          end else begin
            pending_results.push_back(frame_end(c16df_pkg::KIND_CRC_ERR));
            if (last) rx_phase = c16df_pkg::PH_HEADER;
            else rx_phase = c16df_pkg::PH_DISCARD;
          end
        end else if (last) begin
          pending_results.push_back(frame_end(c16df_pkg::KIND_TRUNC));
          rx_phase = c16df_pkg::PH_HEADER;
          rx_pos   = '0;
        end
      end
      c16df_pkg::PH_DISCARD: begin
        if (last) begin
          rx_phase = c16df_pkg::PH_HEADER;
          rx_pos   = '0;
        end
      end
      default: begin
        rx_phase = c16df_pkg::PH_HEADER;
        rx_pos   = '0;
      end
    endcase
  endtask

  // mismatch report
  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string fname, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", fname, got, want));
  endtask

  // result checker: every output transaction against the oldest expectation
  always @(posedge clk_i) begin
    c16df_pkg::result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", kind_o));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(kind_o), 32'(want.kind));
        check_field("payload_byte", 32'(payload_byte_o), 32'(want.payload_byte));
        check_field("byte_index", 32'(byte_index_o), 32'(want.byte_index));
        check_field("cmd", cmd_o, want.cmd);
        check_field("para", para_o, want.para);
        check_field("payload_len", 32'(payload_len_o), 32'(want.payload_len));
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left  = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 12) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // send one byte transaction; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    chunk_end_i <= last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    deframe_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame_buf(input bit close_chunk);
    foreach (frame_buf[i]) send_byte(frame_buf[i], close_chunk && (i == frame_buf.size() - 1));
  endtask

  // header, n random payload bytes and a matching crc into frame_buf
  task automatic build_frame(input logic [31:0] c, input logic [31:0] p,
                             input logic [31:0] l, input int n);
    logic [15:0] crc;
    frame_buf.delete();
    for (int i = 0; i < 4; i++) frame_buf.push_back(c[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame_buf.push_back(p[8*i +: 8]);
    for (int i = 0; i < 4; i++) frame_buf.push_back(l[8*i +: 8]);
    repeat (n) frame_buf.push_back(8'($urandom));
    crc = c16df_pkg::CRC_INIT;
    foreach (frame_buf[i]) crc = crc_next(crc, frame_buf[i]);
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  task automatic trim_frame(input int keep);
    while (frame_buf.size() > keep) void'(frame_buf.pop_back());
  endtask

  // stop offering, wait for every expected result, then let the pipeline empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_max_len(input logic [c16df_pkg::LEN_BITS-1:0] v);
    wait_idle();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    max_len_cfg = v;
  endtask

  // good, crc error and length error frames under the reset limit
  task automatic test_basic_frames();
    build_frame(32'h0000_0000, 32'h0000_0000, 0, 0);
    send_frame_buf(1'b1);
    build_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 3);
    send_frame_buf(1'b1);
    // two frames inside one chunk
    build_frame(32'h1234_5678, 32'h9ABC_DEF0, 1, 1);
    send_frame_buf(1'b0);
    build_frame($urandom, $urandom, 5, 5);
    send_frame_buf(1'b1);
    // bad crc, the following frame of the chunk is dropped
    build_frame($urandom, $urandom, 2, 2);
    frame_buf[frame_buf.size() - 1] ^= 8'h80;
    send_frame_buf(1'b0);
    build_frame($urandom, $urandom, 4, 4);
    send_frame_buf(1'b1);
    // one over the limit, rest of chunk dropped
    build_frame($urandom, $urandom, 32'd1027, 0);
    send_frame_buf(1'b0);
    build_frame($urandom, $urandom, 2, 2);
    send_frame_buf(1'b1);
    build_frame($urandom, $urandom, 1, 1);
    send_frame_buf(1'b1);
  endtask

  // chunks that end before the frame does
  task automatic test_truncation();
    // partial header: missing bytes read as zero
    build_frame(32'hA5A5_A5A5, 32'h5A5A_5A5A, 8, 8);
    trim_frame(6);
    send_frame_buf(1'b1);
    // ends on the last header byte
    build_frame($urandom, $urandom, 4, 4);
    trim_frame(HDR_BYTES);
    send_frame_buf(1'b1);
    // length error on the chunk's last byte, next byte starts a frame
    build_frame($urandom, $urandom, 32'd2000, 0);
    trim_frame(HDR_BYTES);
    send_frame_buf(1'b1);
    build_frame($urandom, $urandom, 2, 2);
    send_frame_buf(1'b1);
    // ends inside the payload
    build_frame($urandom, $urandom, 10, 10);
    trim_frame(17);
    send_frame_buf(1'b1);
    // ends on the first crc byte
    build_frame($urandom, $urandom, 3, 3);
    trim_frame(frame_buf.size() - 1);
    send_frame_buf(1'b1);
    build_frame($urandom, $urandom, 0, 0);
    trim_frame(frame_buf.size() - 1);
    send_frame_buf(1'b1);
    // single byte chunk
    send_byte(8'hFF, 1'b1);
  endtask

  // limit extremes, a payload right at the limit and a saturated length report
  task automatic test_length_limits();
    set_max_len('0);
    build_frame($urandom, $urandom, 0, 0);
    send_frame_buf(1'b1);
    build_frame($urandom, $urandom, 1, 0);
    send_frame_buf(1'b1);
    set_max_len(12'd200);
    build_frame($urandom, $urandom, 32'd200, 200);
    send_frame_buf(1'b1);
    build_frame($urandom, $urandom, 32'd201, 0);
    send_frame_buf(1'b1);
    set_max_len(c16df_pkg::FIELD_MAX);
    // largest length passes the check, chunk ends on the header
    build_frame($urandom, $urandom, 32'd4095, 0);
    trim_frame(HDR_BYTES);
    send_frame_buf(1'b1);
    build_frame($urandom, $urandom, 32'd4096, 0);
    send_frame_buf(1'b1);
    build_frame(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_frame_buf(1'b1);
    set_max_len(12'd1026);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_hold();
    hold_request = 250;
    build_frame($urandom, $urandom, 150, 150);
    send_frame_buf(1'b1);
    build_frame($urandom, $urandom, 20, 20);
    send_frame_buf(1'b1);
  endtask

  // one chunk of one to three frames, mostly well formed
  task automatic random_chunk();
    int          nfr;
    int          pick;
    int          span;
    int          cut;
    int          pos;
    logic [31:0] lenw;
    bit          close_chunk;
    nfr = $urandom_range(1, 3);
    for (int f = 0; f < nfr; f++) begin
      close_chunk = (f == nfr - 1);
      pick = $urandom_range(0, 99);
      span = (max_len_cfg < 24) ? int'(max_len_cfg) : 24;
      if (pick >= 14 && pick < 20) span = (max_len_cfg < 300) ? int'(max_len_cfg) : 300;
      lenw = $urandom_range(0, span);
      if (pick >= 38 && pick < 42 && max_len_cfg <= 300) lenw = 32'(max_len_cfg);
      if (pick >= 5 && pick < 12) lenw = 32'(max_len_cfg) + $urandom_range(1, 3);
      else if (pick >= 12 && pick < 14) lenw = $urandom | 32'h0000_1000;
      build_frame($urandom, $urandom, lenw, (lenw <= 32'(max_len_cfg)) ? int'(lenw) : 0);
      if (pick < 5) begin
        // line noise
        frame_buf.delete();
        repeat ($urandom_range(1, 16)) frame_buf.push_back(8'($urandom));
      end else if (pick >= 20 && pick < 30) begin
        // corrupted byte somewhere in the frame
        pos = $urandom_range(0, frame_buf.size() - 1);
        frame_buf[pos] ^= 8'($urandom_range(1, 255));
      end else if (pick >= 30 && pick < 38) begin
        // chunk cut mid frame
        cut = $urandom_range(1, frame_buf.size() - 1);
        trim_frame(cut);
        close_chunk = 1'b1;
        f = nfr;
      end
      send_frame_buf(close_chunk);
    end
  endtask

  task automatic run_chunks(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) random_chunk();
  endtask

  // random traffic under several limits, the last stretch without idling
  task automatic test_random_traffic();
    logic [c16df_pkg::LEN_BITS-1:0] lim_set[4];
    lim_set[0] = 12'd1026;
    lim_set[1] = 12'($urandom_range(16, 400));
    lim_set[2] = c16df_pkg::FIELD_MAX;
    lim_set[3] = 12'($urandom_range(1, 15));
    foreach (lim_set[s]) begin
      set_max_len(lim_set[s]);
      run_chunks(230);
    end
    idle_on = 1'b0;
    run_chunks(250);
  endtask

  // main sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    chunk_end_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_basic_frames();
    test_truncation();
    test_length_limits();
    test_output_hold();
    test_random_traffic();
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb_crc16_frame_deframer_top: done, clean");
    end else begin
      $display("tb_crc16_frame_deframer_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== crc16_frame_deframer_top.f =====
hw/rtl/c16df_pkg.sv
hw/rtl/c16df_in_reg.sv
hw/rtl/c16df_core.sv
hw/rtl/c16df_out_reg.sv
hw/rtl/crc16_frame_deframer_top.sv
sim/tb_crc16_frame_deframer_top.sv
